FILE: rtl/nrbh_pkg.sv
// Shared types, character codes and calendar constants for the RMC base-hour extractor.
`timescale 1ns / 1ps
package nrbh_pkg;

    typedef enum logic [1:0] {
        ST_FIX   = 2'd0,
        ST_VOID  = 2'd1,
        ST_OTHER = 2'd2,
        ST_BAD   = 2'd3
    } t_fix_status;

    typedef logic [3:0] t_digit;

    // One finished sentence, handed from the parser to the time unit
    typedef struct packed {
        t_fix_status          status;
        logic                 pps_locked;
        logic [1:0][3:0]      hour;
        logic [5:0][3:0]      date;
    } t_rec;

    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_A      = 8'd65;
    localparam logic [7:0] CH_V      = 8'd86;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] PPS_LOCK  = 8'd2;

    localparam logic [3:0] FLD_TIME  = 4'd1;
    localparam logic [3:0] FLD_VALID = 4'd2;
    localparam logic [3:0] FLD_DATE  = 4'd9;
    localparam logic [3:0] COMMA_MAX = 4'd15;
    localparam logic [2:0] HOUR_LEN  = 3'd2;
    localparam logic [2:0] DATE_LEN  = 3'd6;
    localparam logic [2:0] OFF_MAX   = 3'd7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Year arithmetic runs on z = year - 1600, so 400-year terms stay small
    localparam logic [8:0]  Z_CENTURY  = 9'd400;   // 2000 - 1600
    localparam logic [8:0]  Z_PREV     = 9'd399;   // 1999 - 1600
    localparam logic [8:0]  Z_C5       = 9'd500;   // 2100 - 1600
    localparam logic [17:0] DAYS_BIAS  = 18'd135081;
    localparam logic [32:0] SEC_PER_DAY  = 33'd86400;
    localparam logic [18:0] SEC_PER_HOUR = 19'd3600;

    // Day of the March-based year on which shifted month mp starts
    function automatic logic [8:0] doy_of(input logic [3:0] mp);
        logic [8:0] d;
        unique case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/nmea_rmc_base_hour_extractor.sv
// Top level of the RMC sentence base-hour extractor: parser, record queue and time unit.
`timescale 1ns / 1ps
// Takes one sentence character per transfer on the slave side, with the PPS status byte
// beside it, and s_tlast on the final character. Each sentence gives exactly one result
// transfer: fix status, PPS lock and the held UTC epoch seconds of the start of the hour,
// which an 'A' fix with good hour and ddmmyy fields replaces. One character is taken every
// clock cycle while the record queue is not full; the time unit is a five-register pipeline,
// and each record passes from the record queue through those five registers to m_tvalid.
// A four-entry record queue lets the parser keep taking characters while the master side is
// stalled; s_tready drops only when that queue is full. Characters past SENTENCE_BYTES in a
// sentence are ignored.
module nmea_rmc_base_hour_extractor #(
    parameter int SENTENCE_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] nmea_byte, [15:8] pps_status
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [1:0] fix_status, [2] pps_locked,
                                    // [34:3] base_hour_seconds, [39:35] zero
);
    import nrbh_pkg::*;

    logic        q_full;
    logic        push;
    t_rec        push_rec;
    logic        pop;
    logic        q_valid;
    t_rec        head_rec;
    logic [1:0]  fix_status;
    logic        pps_locked;
    logic [31:0] base_hour;

    nrbh_front #(
        .SENTENCE_BYTES(SENTENCE_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_byte      (s_tdata[7:0]),
        .i_pps_status(s_tdata[15:8]),
        .i_last      (s_tlast),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    nrbh_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_rec  (push_rec),
        .o_full (q_full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_rec  (head_rec)
    );

    nrbh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_rec       (head_rec),
        .o_pop       (pop),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_fix_status(fix_status),
        .o_pps_locked(pps_locked),
        .o_base_hour (base_hour)
    );

    assign m_tdata = {5'b0, base_hour, pps_locked, fix_status};

endmodule

FILE: rtl/nrbh_front.sv
// Sentence parser: counts commas, captures hour, validity and date, classifies on the last byte.
`timescale 1ns / 1ps
module nrbh_front #(
    parameter int SENTENCE_BYTES = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_byte,
    input  logic [7:0]      i_pps_status,
    input  logic            i_last,
    input  logic            i_q_full,
    output logic            o_push,
    output nrbh_pkg::t_rec  o_rec
);
    import nrbh_pkg::*;

    localparam int BCW = $clog2(SENTENCE_BYTES + 1);

    logic [3:0]      r_comma, n_comma;
    logic [2:0]      r_off, n_off;
    logic [1:0][3:0] r_hour, n_hour;
    logic [7:0]      r_vchar, n_vchar;
    logic            r_vseen, n_vseen;
    logic [5:0][3:0] r_date, n_date;
    logic            r_err, n_err;
    logic [BCW-1:0]  r_bcnt, n_bcnt;

    logic            accept;
    logic            is_digit;
    logic            fin_err;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);

    always_comb begin
        n_comma = r_comma;
        n_off   = r_off;
        n_hour  = r_hour;
        n_vchar = r_vchar;
        n_vseen = r_vseen;
        n_date  = r_date;
        n_err   = r_err;
        n_bcnt  = r_bcnt;
        fin_err = 1'b0;
        o_push  = 1'b0;
        o_rec   = '0;
        if (accept) begin
            // drop bytes beyond the sentence limit, but still honor the last mark
            if (r_bcnt < BCW'(SENTENCE_BYTES)) begin
                if (i_byte == CH_COMMA) begin
                    if ((r_comma == FLD_TIME && r_off < HOUR_LEN) ||
                        (r_comma == FLD_DATE && r_off < DATE_LEN)) begin
                        n_err = 1'b1;
                    end
                    if (r_comma != COMMA_MAX) begin
                        n_comma = r_comma + 4'd1;
                    end
                    n_off = '0;
                end else begin
                    if (r_comma == FLD_TIME && r_off < HOUR_LEN) begin
                        if (is_digit) begin
                            n_hour[r_off[0]] = i_byte[3:0];
                        end else begin
                            n_err = 1'b1;
                        end
                    end else if (r_comma == FLD_VALID && r_off == 3'd0) begin
                        n_vchar = i_byte;
                        n_vseen = 1'b1;
                    end else if (r_comma == FLD_DATE && r_off < DATE_LEN) begin
                        if (is_digit) begin
                            n_date[r_off] = i_byte[3:0];
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    if (r_off != OFF_MAX) begin
                        n_off = r_off + 3'd1;
                    end
                end
            end
            if (r_bcnt != BCW'(SENTENCE_BYTES)) begin
                n_bcnt = r_bcnt + BCW'(1);
            end
            if (i_last) begin
                fin_err = n_err || (n_comma < FLD_DATE) ||
                          (n_comma == FLD_DATE && n_off < DATE_LEN);
                o_push           = 1'b1;
                o_rec.pps_locked = (i_pps_status == PPS_LOCK);
                o_rec.hour       = n_hour;
                o_rec.date       = n_date;
                if (!n_vseen) begin
                    o_rec.status = ST_BAD;
                end else if (n_vchar == CH_A) begin
                    o_rec.status = fin_err ? ST_BAD : ST_FIX;
                end else if (n_vchar == CH_V) begin
                    o_rec.status = ST_VOID;
                end else begin
                    o_rec.status = ST_OTHER;
                end
                // start the next sentence clean
                n_comma = '0;
                n_off   = '0;
                n_hour  = '0;
                n_vchar = '0;
                n_vseen = 1'b0;
                n_date  = '0;
                n_err   = 1'b0;
                n_bcnt  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comma <= '0;
            r_off   <= '0;
            r_hour  <= '0;
            r_vchar <= '0;
            r_vseen <= 1'b0;
            r_date  <= '0;
            r_err   <= 1'b0;
            r_bcnt  <= '0;
        end else begin
            r_comma <= n_comma;
            r_off   <= n_off;
            r_hour  <= n_hour;
            r_vchar <= n_vchar;
            r_vseen <= n_vseen;
            r_date  <= n_date;
            r_err   <= n_err;
            r_bcnt  <= n_bcnt;
        end
    end

`ifndef NO_ASSERTIONS
    a_push_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (accept && i_last))
        else $error("sentence record pushed without a last byte");
    a_cleared_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_comma == 4'd0 && !r_vseen && !r_err))
        else $error("parse state not cleared after last byte");
    a_fix_needs_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_rec.status == ST_FIX) |-> (n_vchar == CH_A || r_vchar == CH_A ||
                                                i_byte == CH_A))
        else $error("fix reported without an A validity character");
`endif

endmodule

FILE: rtl/nrbh_queue.sv
// Short record queue between the parser and the time unit.
`timescale 1ns / 1ps
module nrbh_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nrbh_pkg::t_rec  i_rec,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output nrbh_pkg::t_rec  o_rec
);
    import nrbh_pkg::*;

    t_rec              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_slot[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (QPTR_W + 1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue write while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || o_full) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

FILE: rtl/nrbh_back.sv
// Time unit: turns ddmmyy and hh into epoch seconds of the hour, holds the base hour, drives results.
`timescale 1ns / 1ps
module nrbh_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  nrbh_pkg::t_rec  i_rec,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_fix_status,
    output logic            o_pps_locked,
    output logic [31:0]     o_base_hour
);
    import nrbh_pkg::*;

    logic adv;

    // stage 1: decimal to binary
    logic        r1_v;
    t_fix_status r1_status;
    logic        r1_pps;
    logic [6:0]  r1_yy, r1_mm, r1_dd, r1_hh;
    // stage 2: month normalization, year offset
    logic        r2_v;
    t_fix_status r2_status;
    logic        r2_pps;
    logic [8:0]  r2_z;
    logic [3:0]  r2_mp;
    logic [6:0]  r2_dd, r2_hh;
    // stage 3: day count
    logic        r3_v;
    t_fix_status r3_status;
    logic        r3_pps;
    logic [15:0] r3_days;
    logic [18:0] r3_hsec;
    // stage 4: seconds
    logic        r4_v;
    t_fix_status r4_status;
    logic        r4_pps;
    logic [31:0] r4_secs;
    // result register and held base hour
    logic        r_out_v;
    t_fix_status r_out_status;
    logic        r_out_pps;
    logic [31:0] r_out_base;
    logic [31:0] r_held;

    logic [6:0]  mmx;
    logic [3:0]  q;
    logic [3:0]  mon;
    logic [8:0]  z_mon;
    logic [8:0]  n_z;
    logic [3:0]  n_mp;
    logic [2:0]  zc;
    logic [17:0] days18;

    // whole pipeline moves while the result register can take a new value
    assign adv   = !r_out_v || i_ready;
    assign o_pop = i_q_valid && adv;

    always_comb begin
        mmx = r1_mm - 7'd1;
        q   = '0;
        for (int k = 1; k <= 8; k++) begin
            if (mmx >= 7'(12 * k)) begin
                q = q + 4'd1;
            end
        end
        if (r1_mm == 7'd0) begin
            mon   = 4'd12;
            z_mon = 9'(r1_yy) + Z_PREV;
        end else begin
            mon   = 4'(mmx - 7'(q) * 7'd12) + 4'd1;
            z_mon = 9'(r1_yy) + Z_CENTURY + 9'(q);
        end
        // count January and February with the previous year
        if (mon <= 4'd2) begin
            n_z  = z_mon - 9'd1;
            n_mp = mon + 4'd9;
        end else begin
            n_z  = z_mon;
            n_mp = mon - 4'd3;
        end
    end

    always_comb begin
        if (r2_z >= Z_C5) begin
            zc = 3'd5;
        end else if (r2_z >= Z_CENTURY) begin
            zc = 3'd4;
        end else begin
            zc = 3'd3;
        end
        days18 = 18'(r2_z) * 18'd365 + 18'(r2_z >> 2) - 18'(zc)
               + 18'(r2_z >= Z_CENTURY) + 18'(doy_of(r2_mp)) + 18'(r2_dd) - DAYS_BIAS;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_status <= i_rec.status;
            r1_pps    <= i_rec.pps_locked;
            r1_yy     <= 7'(i_rec.date[4]) * 7'd10 + 7'(i_rec.date[5]);
            r1_mm     <= 7'(i_rec.date[2]) * 7'd10 + 7'(i_rec.date[3]);
            r1_dd     <= 7'(i_rec.date[0]) * 7'd10 + 7'(i_rec.date[1]);
            r1_hh     <= 7'(i_rec.hour[0]) * 7'd10 + 7'(i_rec.hour[1]);

            r2_status <= r1_status;
            r2_pps    <= r1_pps;
            r2_z      <= n_z;
            r2_mp     <= n_mp;
            r2_dd     <= r1_dd;
            r2_hh     <= r1_hh;

            r3_status <= r2_status;
            r3_pps    <= r2_pps;
            r3_days   <= days18[15:0];
            r3_hsec   <= 19'(r2_hh) * SEC_PER_HOUR;

            r4_status <= r3_status;
            r4_pps    <= r3_pps;
            r4_secs   <= 32'(33'(r3_days) * SEC_PER_DAY) + 32'(r3_hsec);

            if (r4_v) begin
                r_out_status <= r4_status;
                r_out_pps    <= r4_pps;
                r_out_base   <= (r4_status == ST_FIX) ? r4_secs : r_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r_out_v <= 1'b0;
            r_held  <= '0;
        end else if (adv) begin
            r1_v    <= i_q_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r_out_v <= r4_v;
            if (r4_v && r4_status == ST_FIX) begin
                r_held <= r4_secs;
            end
        end
    end

    assign o_valid      = r_out_v;
    assign o_fix_status = r_out_status;
    assign o_pps_locked = r_out_pps;
    assign o_base_hour  = r_out_base;

`ifndef NO_ASSERTIONS
    a_held_on_fix_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_held) |-> $past(adv && r4_v && r4_status == ST_FIX))
        else $error("base hour changed without a fix");
    a_fix_shows_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_status == ST_FIX) |-> (r_out_base == r_held))
        else $error("fix result disagrees with held base hour");
    a_result_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(r4_v))
        else $error("result appeared without a record in the last stage");
`endif

endmodule
